/* rtl/core/signed_int_to_decimal_ascii_macros.svh */
// assertion macros for the signed integer to decimal ascii block
// expects i_clk and i_rst_n in the scope where a macro is used
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_MACROS_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_MACROS_SVH

// same-cycle implication, checked out of reset
`define SITOD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define SITOD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/sitod_pkg.sv */
// shared types and constants for the signed integer to decimal ascii block
// no dependencies
package sitod_pkg;

    localparam int VALUE_WIDTH = 32;
    // decimal digits of 2^(VALUE_WIDTH-1); 1233/4096 approximates log10(2)
    localparam int NUM_DIGITS  = (((VALUE_WIDTH - 1) * 1233) >> 12) + 1;
    localparam int DIGIT_WIDTH = 4;
    localparam int IDX_WIDTH   = $clog2(NUM_DIGITS);
    localparam int CNT_WIDTH   = $clog2(VALUE_WIDTH);
    localparam int CHAR_WIDTH  = 8;

    localparam logic [CHAR_WIDTH-1:0]  ASCII_ZERO  = 8'd48;
    localparam logic [CHAR_WIDTH-1:0]  ASCII_NINE  = 8'd57;
    localparam logic [CHAR_WIDTH-1:0]  ASCII_MINUS = 8'd45;
    localparam logic [DIGIT_WIDTH-1:0] BCD_LIMIT   = 4'd5;
    localparam logic [DIGIT_WIDTH-1:0] BCD_ADJUST  = 4'd3;

    typedef logic [NUM_DIGITS-1:0][DIGIT_WIDTH-1:0] t_digit_vec;

    typedef struct packed {
        logic clear;
        logic shift;
    } t_cell_ctrl;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_LEAD,
        S_EMIT
    } t_state;

endpackage

/* rtl/core/sitod_in_if.sv */
// input channel: one signed value per transfer
// depends on sitod_pkg
interface sitod_in_if;
    import sitod_pkg::*;

    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

/* rtl/core/sitod_out_if.sv */
// output channel: one ascii character per transfer, last marks end of text
// depends on sitod_pkg
interface sitod_out_if;
    import sitod_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CHAR_WIDTH-1:0] character;
    logic                  last;

    modport source (output valid, output character, output last, input ready);
    modport sink   (input valid, input character, input last, output ready);
endinterface

/* rtl/core/sitod_bcd_cell.sv */
// one bcd digit of the double-dabble chain: add-3 then shift left one bit
// depends on sitod_pkg
module sitod_bcd_cell (
    input  logic                            i_clk,
    input  sitod_pkg::t_cell_ctrl           i_ctrl,
    input  logic                            i_carry,
    output logic                            o_carry,
    output logic [sitod_pkg::DIGIT_WIDTH-1:0] o_digit
);
    import sitod_pkg::*;

    logic [DIGIT_WIDTH-1:0] r_digit;
    logic [DIGIT_WIDTH-1:0] n_digit;
    logic [DIGIT_WIDTH-1:0] w_adj;

    assign w_adj   = (r_digit >= BCD_LIMIT) ? r_digit + BCD_ADJUST : r_digit;
    assign o_carry = w_adj[DIGIT_WIDTH-1];
    assign o_digit = r_digit;

    always_comb begin
        n_digit = r_digit;
        if (i_ctrl.clear) begin
            n_digit = '0;
        end else if (i_ctrl.shift) begin
            n_digit = {w_adj[DIGIT_WIDTH-2:0], i_carry};
        end
    end

    always_ff @(posedge i_clk) begin
        r_digit <= n_digit;
    end

endmodule

/* rtl/core/sitod_bcd_chain.sv */
// row of bcd cells, least significant digit at index 0, fed one bit a cycle
// depends on sitod_pkg and sitod_bcd_cell
module sitod_bcd_chain (
    input  logic                  i_clk,
    input  sitod_pkg::t_cell_ctrl i_ctrl,
    input  logic                  i_serial,
    output sitod_pkg::t_digit_vec o_digits
);
    import sitod_pkg::*;

    logic [NUM_DIGITS-1:0] w_carry;

    assign w_carry[0] = i_serial;

    for (genvar g = 0; g < NUM_DIGITS; g++) begin : g_cell
        if (g < NUM_DIGITS - 1) begin : g_mid
            sitod_bcd_cell u_cell (
                .i_clk   (i_clk),
                .i_ctrl  (i_ctrl),
                .i_carry (w_carry[g]),
                .o_carry (w_carry[g+1]),
                .o_digit (o_digits[g])
            );
        end else begin : g_top
            // magnitude always fits, so the top carry stays low
            sitod_bcd_cell u_cell (
                .i_clk   (i_clk),
                .i_ctrl  (i_ctrl),
                .i_carry (w_carry[g]),
                .o_carry (),
                .o_digit (o_digits[g])
            );
        end
    end

endmodule

/* rtl/core/signed_int_to_decimal_ascii.sv */
// signed integer to decimal ascii text, top level
// depends on sitod_pkg, sitod_in_if, sitod_out_if, sitod_bcd_chain and the macro header
//
// usage:
//   i_in   takes one signed VALUE_WIDTH-bit value per transfer (valid/ready)
//   o_out  gives its decimal text, one ascii character per transfer, most
//          significant digit first, '-' ahead of negative values, no leading
//          zeros, last high on the final character
// timing:
//   a value goes bit-serially into a row of bcd cells (double dabble), one
//   bit per cycle, then the leading digit is found in state S_LEAD, then
//   one character per cycle while o_out drains
//   i_in.ready is high only while idle, with no conversion or emission in
//   progress; the last character may still sit in the output register when
//   the next value is taken
// reset:
//   synchronous active-low i_rst_n drops any item in progress and empties
//   the output register
// stall:
//   a low o_out.ready holds the output register and pauses emission; no
//   character is lost or repeated
module signed_int_to_decimal_ascii (
    input  logic         i_clk,
    input  logic         i_rst_n,
    sitod_in_if.sink     i_in,
    sitod_out_if.source  o_out
);
    import sitod_pkg::*;

    `include "signed_int_to_decimal_ascii_macros.svh"

    // control state
    t_state                 r_state;
    t_state                 n_state;

    // datapath registers
    logic [VALUE_WIDTH-1:0] r_mag;
    logic [VALUE_WIDTH-1:0] n_mag;
    logic [CNT_WIDTH-1:0]   r_cnt;
    logic [CNT_WIDTH-1:0]   n_cnt;
    logic                   r_sign;
    logic                   n_sign;
    logic [IDX_WIDTH-1:0]   r_idx;
    logic [IDX_WIDTH-1:0]   n_idx;

    // output register
    logic                   r_out_valid;
    logic                   n_out_valid;
    logic [CHAR_WIDTH-1:0]  r_char;
    logic [CHAR_WIDTH-1:0]  n_char;
    logic                   r_last;
    logic                   n_last;

    // control decode
    logic                   w_in_ready;
    logic                   w_accept;
    logic                   w_out_free;
    logic                   w_emit;
    logic                   w_conv_done;
    t_cell_ctrl             w_ctrl;

    // digit row
    t_digit_vec             w_digits;
    logic [IDX_WIDTH-1:0]   w_lead;
    logic [VALUE_WIDTH-1:0] w_raw;

    // character class of the output register, for the checks below
    logic                   w_char_minus;
    logic                   w_char_digit;

    assign w_raw       = i_in.value;
    assign w_accept    = i_in.valid && w_in_ready;
    assign w_out_free  = !r_out_valid || o_out.ready;
    assign w_conv_done = (r_cnt == CNT_WIDTH'(VALUE_WIDTH - 1));

    assign i_in.ready      = w_in_ready;
    assign o_out.valid     = r_out_valid;
    assign o_out.character = r_char;
    assign o_out.last      = r_last;

    assign w_char_minus = (r_char == ASCII_MINUS);
    assign w_char_digit = (r_char >= ASCII_ZERO) && (r_char <= ASCII_NINE);

    // msb of the magnitude enters the least significant cell each cycle of conversion
    sitod_bcd_chain u_chain (
        .i_clk    (i_clk),
        .i_ctrl   (w_ctrl),
        .i_serial (r_mag[VALUE_WIDTH-1]),
        .o_digits (w_digits)
    );

    // highest nonzero digit, zero value gives index 0
    always_comb begin
        w_lead = '0;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (w_digits[i] != '0) begin
                w_lead = IDX_WIDTH'(i);
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_CONV;
                end
            end
            S_CONV: begin
                if (w_conv_done) begin
                    n_state = S_LEAD;
                end
            end
            S_LEAD: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (w_emit && !r_sign && (r_idx == '0)) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        w_in_ready   = 1'b0;
        w_ctrl.clear = 1'b0;
        w_ctrl.shift = 1'b0;
        w_emit       = 1'b0;
        case (r_state)
            S_IDLE: begin
                w_in_ready   = 1'b1;
                w_ctrl.clear = i_in.valid;
            end
            S_CONV: begin
                w_ctrl.shift = 1'b1;
            end
            S_LEAD: begin
            end
            S_EMIT: begin
                w_emit = w_out_free;
            end
            default: begin
            end
        endcase
    end

    // datapath next values
    always_comb begin
        n_mag       = r_mag;
        n_cnt       = r_cnt;
        n_sign      = r_sign;
        n_idx       = r_idx;
        n_out_valid = r_out_valid && !o_out.ready;
        n_char      = r_char;
        n_last      = r_last;

        if (w_accept) begin
            // magnitude of the most negative value still fits unsigned
            n_mag  = w_raw[VALUE_WIDTH-1] ? (~w_raw + 1'b1) : w_raw;
            n_sign = w_raw[VALUE_WIDTH-1];
            n_cnt  = '0;
        end

        if (w_ctrl.shift) begin
            n_mag = {r_mag[VALUE_WIDTH-2:0], 1'b0};
            n_cnt = r_cnt + 1'b1;
        end

        if (r_state == S_LEAD) begin
            n_idx = w_lead;
        end

        if (w_emit) begin
            n_out_valid = 1'b1;
            if (r_sign) begin
                n_char = ASCII_MINUS;
                n_last = 1'b0;
                n_sign = 1'b0;
            end else begin
                n_char = ASCII_ZERO + {{(CHAR_WIDTH - DIGIT_WIDTH){1'b0}}, w_digits[r_idx]};
                n_last = (r_idx == '0);
                if (r_idx != '0) begin
                    n_idx = r_idx - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_sign      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_sign      <= n_sign;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag  <= n_mag;
        r_cnt  <= n_cnt;
        r_idx  <= n_idx;
        r_char <= n_char;
        r_last <= n_last;
    end

    // a minus sign never closes a text
    `SITOD_ASSERT_NOW(a_minus_not_last, o_out.valid && w_char_minus, !o_out.last, "minus is last")

    // only minus or decimal digits leave the block
    `SITOD_ASSERT_NOW(a_char_range, o_out.valid, w_char_minus || w_char_digit, "bad character")

    // a new value is taken only once the previous text is complete
    `SITOD_ASSERT_NOW(a_accept_after_text, w_accept && o_out.valid, o_out.last, "taken mid-text")

    // conversion always runs through the leading digit search next
    `SITOD_ASSERT_NEXT(a_conv_to_lead, w_ctrl.shift && w_conv_done, r_state == S_LEAD, "bad exit")

endmodule
